/* hdl/capture_record_stream_parser_defines.svh */
// ----------------------------------------------------------------------------
// capture record stream parser assertion macros
// shared concurrent assertion forms for the parser modules
// ----------------------------------------------------------------------------
`ifndef CAPTURE_RECORD_STREAM_PARSER_DEFINES_SVH
`define CAPTURE_RECORD_STREAM_PARSER_DEFINES_SVH

// condition holds at every edge out of reset
`define CRSP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent must hold after the antecedent, as a non-overlapping implication
`define CRSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/crsp_pkg.sv */
// ----------------------------------------------------------------------------
// crsp_pkg
// types, codes and constants shared by the capture record stream parser
// ----------------------------------------------------------------------------
package crsp_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  direction;
      logic [7:0]  request_flag;
      logic [15:0] stream_id;
      logic [15:0] op_code;
      logic [31:0] wire_length;
      logic [7:0]  key_length;
      logic [15:0] value_length;
      logic [31:0] frame_count;
      logic [31:0] meta_count;
   } rsp_type;

   typedef struct packed {
      logic       is_end;
      logic       is_meta_tag;
      logic       is_frame_tag;
      logic [7:0] data_byte;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_TYPE,
      PH_M_KLEN,
      PH_M_KEY,
      PH_M_VLEN,
      PH_M_VAL,
      PH_F_DIR,
      PH_F_REQ,
      PH_F_SID,
      PH_F_CODE,
      PH_F_LEN,
      PH_F_WIRE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_CORRUPT,
      ERR_MAGIC
   } err_type;

   localparam logic [2:0] STATUS_META      = 3'd0;
   localparam logic [2:0] STATUS_FRAME     = 3'd1;
   localparam logic [2:0] STATUS_CLEAN     = 3'd2;
   localparam logic [2:0] STATUS_CORRUPT   = 3'd3;
   localparam logic [2:0] STATUS_BAD_MAGIC = 3'd4;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0]  TAG_META         = 8'h4D;
   localparam logic [7:0]  TAG_FRAME        = 8'h46;
   localparam logic [31:0] WIRE_LIMIT_RESET = 32'd16777280;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   // expected prefix byte, zero beyond the eighth
   function automatic logic [7:0] magic_byte(input logic [3:0] idx);
      logic [7:0] value;
      case (idx)
         4'd0:    value = 8'h58;
         4'd1:    value = 8'h52;
         4'd2:    value = 8'h44;
         4'd3:    value = 8'h43;
         4'd4:    value = 8'h41;
         4'd5:    value = 8'h50;
         4'd6:    value = 8'h31;
         4'd7:    value = 8'h0A;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

/* hdl/crsp_fifo.sv */
// ----------------------------------------------------------------------------
// crsp_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`include "capture_record_stream_parser_defines.svh"

module crsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = PTR_BITS + 1;

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CRSP_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_BITS'(DEPTH), "queue overfilled")
   `CRSP_ASSERT_NEXT(a_count_up, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "push lost")
   `CRSP_ASSERT_NEXT(a_count_down, clock, reset, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1, "pop lost")

endmodule

/* hdl/crsp_front.sv */
// ----------------------------------------------------------------------------
// crsp_front
// accepts input words and tags them for the record parser
// ----------------------------------------------------------------------------
module crsp_front
   import crsp_pkg::*;
(
   input  logic    req_push,
   input  req_type req,
   output logic    req_full,
   input  logic    cmd_full,
   output logic    cmd_push,
   output cmd_type cmd
);

   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

   always_comb begin
      cmd.is_end       = (req.kind == KIND_END);
      cmd.is_meta_tag  = (req.data_byte == TAG_META);
      cmd.is_frame_tag = (req.data_byte == TAG_FRAME);
      cmd.data_byte    = req.data_byte;
   end

endmodule

/* hdl/crsp_back.sv */
// ----------------------------------------------------------------------------
// crsp_back
// record parser state machine, field capture and result build
// ----------------------------------------------------------------------------
`include "capture_record_stream_parser_defines.svh"

module crsp_back
   import crsp_pkg::*;
#(
   parameter int MAGIC_BYTES = 8,
   parameter int COUNT_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   input  logic        rsp_full,
   output logic        rsp_push,
   output rsp_type     rsp,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);

   localparam int MIDX_BITS = (MAGIC_BYTES > 1) ? $clog2(MAGIC_BYTES) : 1;
   localparam logic [MIDX_BITS-1:0] MIDX_LAST = MIDX_BITS'(MAGIC_BYTES - 1);

   phase_type              phase_ff, phase_in;
   err_type                err_ff, err_in;
   logic [MIDX_BITS-1:0]   midx_ff, midx_in;
   logic [1:0]             fbi_ff, fbi_in;
   logic [31:0]            skip_ff, skip_in;
   logic [7:0]             dir_ff, dir_in;
   logic [7:0]             reqf_ff, reqf_in;
   logic [15:0]            sid_ff, sid_in;
   logic [15:0]            code_ff, code_in;
   logic [31:0]            len_ff, len_in;
   logic [7:0]             klen_ff, klen_in;
   logic [COUNT_BITS-1:0]  frames_ff, frames_in;
   logic [COUNT_BITS-1:0]  metas_ff, metas_in;
   logic [31:0]            max_len_ff;

   logic        step;
   logic [7:0]  b;
   logic        magic_ok;
   logic [31:0] wire_len_next;
   logic [15:0] value_len_next;
   logic        skip_last;

   assign step           = cmd_valid && !rsp_full;
   assign cmd_pop        = step;
   assign b              = cmd.data_byte;
   assign magic_ok       = (b == magic_byte(4'(midx_ff)));
   assign wire_len_next  = (fbi_ff == 2'd0) ? {24'd0, b} : {len_ff[23:0], b};
   assign value_len_next = {len_ff[7:0], b};
   assign skip_last      = (skip_ff == 32'd1);

   // next state
   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      if (step) begin
         if (cmd.is_end) begin
            phase_in = PH_MAGIC;
            err_in   = ERR_NONE;
         end else begin
            case (phase_ff)
               PH_MAGIC: begin
                  if (!magic_ok) begin
                     phase_in = PH_ERROR;
                     err_in   = ERR_MAGIC;
                  end else if (midx_ff == MIDX_LAST) begin
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  if (cmd.is_meta_tag) begin
                     phase_in = PH_M_KLEN;
                  end else if (cmd.is_frame_tag) begin
                     phase_in = PH_F_DIR;
                  end else begin
                     phase_in = PH_ERROR;
                     err_in   = ERR_CORRUPT;
                  end
               end
               PH_M_KLEN: phase_in = (b == 8'd0) ? PH_M_VLEN : PH_M_KEY;
               PH_M_KEY: begin
                  if (skip_last) phase_in = PH_M_VLEN;
               end
               PH_M_VLEN: begin
                  if (fbi_ff != 2'd0) begin
                     phase_in = (value_len_next == 16'd0) ? PH_TYPE : PH_M_VAL;
                  end
               end
               PH_M_VAL: begin
                  if (skip_last) phase_in = PH_TYPE;
               end
               PH_F_DIR: phase_in = PH_F_REQ;
               PH_F_REQ: phase_in = PH_F_SID;
               PH_F_SID: begin
                  if (fbi_ff != 2'd0) phase_in = PH_F_CODE;
               end
               PH_F_CODE: begin
                  if (fbi_ff != 2'd0) phase_in = PH_F_LEN;
               end
               PH_F_LEN: begin
                  if (fbi_ff == 2'd3) begin
                     if (wire_len_next > max_len_ff) begin
                        phase_in = PH_ERROR;
                        err_in   = ERR_CORRUPT;
                     end else if (wire_len_next == 32'd0) begin
                        phase_in = PH_TYPE;
                     end else begin
                        phase_in = PH_F_WIRE;
                     end
                  end
               end
               PH_F_WIRE: begin
                  if (skip_last) phase_in = PH_TYPE;
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // field capture and results
   always_comb begin
      midx_in   = midx_ff;
      fbi_in    = fbi_ff;
      skip_in   = skip_ff;
      dir_in    = dir_ff;
      reqf_in   = reqf_ff;
      sid_in    = sid_ff;
      code_in   = code_ff;
      len_in    = len_ff;
      klen_in   = klen_ff;
      frames_in = frames_ff;
      metas_in  = metas_ff;
      rsp_push  = 1'b0;
      rsp       = '0;
      if (step) begin
         if (cmd.is_end) begin
            rsp_push = 1'b1;
            if (err_ff == ERR_MAGIC || phase_ff == PH_MAGIC) begin
               rsp.status = STATUS_BAD_MAGIC;
            end else if (err_ff == ERR_CORRUPT || phase_ff != PH_TYPE) begin
               rsp.status = STATUS_CORRUPT;
            end else begin
               rsp.status = STATUS_CLEAN;
            end
            rsp.frame_count = 32'(frames_ff);
            rsp.meta_count  = 32'(metas_ff);
            midx_in   = '0;
            fbi_in    = '0;
            skip_in   = '0;
            dir_in    = '0;
            reqf_in   = '0;
            sid_in    = '0;
            code_in   = '0;
            len_in    = '0;
            klen_in   = '0;
            frames_in = '0;
            metas_in  = '0;
         end else begin
            case (phase_ff)
               PH_MAGIC: begin
                  if (magic_ok) begin
                     midx_in = (midx_ff == MIDX_LAST) ? '0 : midx_ff + 1'b1;
                  end
               end
               PH_M_KLEN: begin
                  klen_in = b;
                  skip_in = {24'd0, b};
                  fbi_in  = '0;
               end
               PH_M_KEY: begin
                  skip_in = skip_ff - 1'b1;
                  if (skip_last) fbi_in = '0;
               end
               PH_M_VLEN: begin
                  if (fbi_ff == 2'd0) begin
                     len_in = {24'd0, b};
                     fbi_in = 2'd1;
                  end else begin
                     len_in  = {16'd0, value_len_next};
                     fbi_in  = '0;
                     skip_in = {16'd0, value_len_next};
                     if (value_len_next == 16'd0) begin
                        rsp_push = 1'b1;
                     end
                  end
               end
               PH_M_VAL: begin
                  skip_in = skip_ff - 1'b1;
                  if (skip_last) rsp_push = 1'b1;
               end
               PH_F_DIR: dir_in = b;
               PH_F_REQ: begin
                  reqf_in = b;
                  fbi_in  = '0;
               end
               PH_F_SID: begin
                  sid_in = (fbi_ff == 2'd0) ? {8'd0, b} : {sid_ff[7:0], b};
                  fbi_in = (fbi_ff == 2'd0) ? 2'd1 : 2'd0;
               end
               PH_F_CODE: begin
                  code_in = (fbi_ff == 2'd0) ? {8'd0, b} : {code_ff[7:0], b};
                  fbi_in  = (fbi_ff == 2'd0) ? 2'd1 : 2'd0;
               end
               PH_F_LEN: begin
                  len_in = wire_len_next;
                  if (fbi_ff != 2'd3) begin
                     fbi_in = fbi_ff + 1'b1;
                  end else begin
                     fbi_in = '0;
                     if (wire_len_next <= max_len_ff) begin
                        skip_in = wire_len_next;
                        if (wire_len_next == 32'd0) rsp_push = 1'b1;
                     end
                  end
               end
               PH_F_WIRE: begin
                  skip_in = skip_ff - 1'b1;
                  if (skip_last) rsp_push = 1'b1;
               end
               default: skip_in = skip_ff;
            endcase
            if (rsp_push) begin
               if (phase_ff == PH_M_VLEN || phase_ff == PH_M_VAL) begin
                  metas_in         = (&metas_ff) ? metas_ff : metas_ff + 1'b1;
                  rsp.status       = STATUS_META;
                  rsp.key_length   = klen_in;
                  rsp.value_length = len_in[15:0];
               end else begin
                  frames_in        = (&frames_ff) ? frames_ff : frames_ff + 1'b1;
                  rsp.status       = STATUS_FRAME;
                  rsp.direction    = dir_in;
                  rsp.request_flag = reqf_in;
                  rsp.stream_id    = sid_in;
                  rsp.op_code      = code_in;
                  rsp.wire_length  = len_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC;
         err_ff     <= ERR_NONE;
         midx_ff    <= '0;
         fbi_ff     <= '0;
         skip_ff    <= '0;
         dir_ff     <= '0;
         reqf_ff    <= '0;
         sid_ff     <= '0;
         code_ff    <= '0;
         len_ff     <= '0;
         klen_ff    <= '0;
         frames_ff  <= '0;
         metas_ff   <= '0;
         max_len_ff <= WIRE_LIMIT_RESET;
      end else begin
         phase_ff  <= phase_in;
         err_ff    <= err_in;
         midx_ff   <= midx_in;
         fbi_ff    <= fbi_in;
         skip_ff   <= skip_in;
         dir_ff    <= dir_in;
         reqf_ff   <= reqf_in;
         sid_ff    <= sid_in;
         code_ff   <= code_in;
         len_ff    <= len_in;
         klen_ff   <= klen_in;
         frames_ff <= frames_in;
         metas_ff  <= metas_in;
         if (csr_write_en) begin
            max_len_ff <= csr_write_data;
         end
      end
   end

   `CRSP_ASSERT_ALWAYS(a_err_phase, clock, reset, (phase_ff == PH_ERROR) == (err_ff != ERR_NONE), "error kind out of step with phase")
   `CRSP_ASSERT_NEXT(a_end_clears, clock, reset, step && cmd.is_end, phase_ff == PH_MAGIC && frames_ff == '0 && metas_ff == '0, "end word did not clear parser")
   `CRSP_ASSERT_NEXT(a_frames_grow, clock, reset, !(step && cmd.is_end), frames_ff >= $past(frames_ff), "frame count went down")

endmodule

/* hdl/capture_record_stream_parser.sv */
// a word is registered in the command queue and parsed from its head; any result is registered in the result queue
// throughput: one word per cycle while the result queue is not full, each word is one step of the parser state machine
// the parser stalls only when the result queue is full; the input side then fills its queue
// reset: synchronous, clears both queues and all parse state, length limit back to 16777280
// no memory clearing pass after reset; words are taken the cycle after reset drops
// ----------------------------------------------------------------------------
// capture_record_stream_parser
// capture byte stream parser: magic check, meta and frame records, summary
// ----------------------------------------------------------------------------
module capture_record_stream_parser
   import crsp_pkg::*;
#(
   parameter int MAGIC_BYTES = 8,
   parameter int COUNT_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);

   localparam int CMD_WIDTH = $bits(cmd_type);
   localparam int RSP_WIDTH = $bits(rsp_type);

   logic                 cmd_push;
   logic                 cmd_full;
   logic                 cmd_empty;
   logic                 cmd_pop;
   cmd_type              cmd_in;
   cmd_type              cmd_head;
   logic [CMD_WIDTH-1:0] cmd_head_vec;
   logic                 back_rsp_push;
   logic                 back_rsp_full;
   rsp_type              back_rsp;
   logic [RSP_WIDTH-1:0] rsp_vec;

   crsp_front u_front (
      .req_push (req_push),
      .req      (req_data),
      .req_full (req_full),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_in)
   );

   crsp_fifo #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (CMD_WIDTH'(cmd_in)),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head_vec),
      .empty     (cmd_empty)
   );

   assign cmd_head = cmd_type'(cmd_head_vec);

   crsp_back #(
      .MAGIC_BYTES (MAGIC_BYTES),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (!cmd_empty),
      .cmd            (cmd_head),
      .cmd_pop        (cmd_pop),
      .rsp_full       (back_rsp_full),
      .rsp_push       (back_rsp_push),
      .rsp            (back_rsp),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   crsp_fifo #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_rsp_push),
      .push_data (RSP_WIDTH'(back_rsp)),
      .full      (back_rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_vec),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_vec);

endmodule
